[hw/rtl/sin_cos_taylor_degrees_assert.svh]
// Assertion shorthands for the checker file of this block.
`ifndef SIN_COS_TAYLOR_DEGREES_ASSERT_SVH
`define SIN_COS_TAYLOR_DEGREES_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define SCT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sct check failed");

// Next-cycle implication, off while reset is high.
`define SCT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sct check failed");

// Next-cycle implication that also runs through reset.
`define SCT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sct check failed");

`endif

[hw/rtl/sct_pkg.sv]
`timescale 1ns / 1ps

package sct_pkg;

  localparam int unsigned ANGLE_W      = 24;
  localparam int unsigned TRIG_W       = 18;
  localparam int unsigned TERM_COUNT_W = 4;
  localparam logic [TERM_COUNT_W-1:0] TERM_COUNT_RESET = 4'd8;

  // Series tables cover k = 1 .. KTAB
  localparam int unsigned KTAB   = 12;
  localparam int unsigned K_W    = 4;
  localparam int unsigned STEP_W = 3;
  // Turn reduction subtracts 360 deg << j for j = RED_TOP .. 0
  localparam logic [STEP_W-1:0] RED_TOP = 3'd6;

  // Angles in degrees with 8 fraction bits
  localparam logic [23:0] DEG_FULL = 24'd92160;
  localparam logic [23:0] DEG_270  = 24'd69120;
  localparam logic [23:0] DEG_180  = 24'd46080;
  localparam logic [23:0] DEG_90   = 24'd23040;
  localparam logic [14:0] T_90     = 15'd23040;
  localparam logic [14:0] T_45     = 15'd11520;

  localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
  localparam logic [32:0] RAD_Q46 = 33'((PI_Q60 / 64'd46080) >> 14);
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // Term divisors: sine 2k(2k+1), cosine (2k-1)2k
  localparam logic [9:0] SIN_DIV [KTAB] = '{
    10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156,
    10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600};
  localparam logic [9:0] COS_DIV [KTAB] = '{
    10'd2, 10'd12, 10'd30, 10'd56, 10'd90, 10'd132,
    10'd182, 10'd240, 10'd306, 10'd380, 10'd462, 10'd552};

  // Reciprocal shift: 30 + ceil(log2(divisor))
  localparam logic [5:0] SIN_SHIFT [KTAB] = '{
    6'd33, 6'd35, 6'd36, 6'd37, 6'd37, 6'd38,
    6'd38, 6'd39, 6'd39, 6'd39, 6'd39, 6'd40};
  localparam logic [5:0] COS_SHIFT [KTAB] = '{
    6'd31, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38,
    6'd38, 6'd38, 6'd39, 6'd39, 6'd39, 6'd40};

  // floor(2^shift / divisor), always in [2^30, 2^31)
  localparam logic [30:0] SIN_RCP [KTAB] = '{
    31'((64'd1 << 33) / 64'd6),   31'((64'd1 << 35) / 64'd20),
    31'((64'd1 << 36) / 64'd42),  31'((64'd1 << 37) / 64'd72),
    31'((64'd1 << 37) / 64'd110), 31'((64'd1 << 38) / 64'd156),
    31'((64'd1 << 38) / 64'd210), 31'((64'd1 << 39) / 64'd272),
    31'((64'd1 << 39) / 64'd342), 31'((64'd1 << 39) / 64'd420),
    31'((64'd1 << 39) / 64'd506), 31'((64'd1 << 40) / 64'd600)};
  localparam logic [30:0] COS_RCP [KTAB] = '{
    31'((64'd1 << 31) / 64'd2),   31'((64'd1 << 34) / 64'd12),
    31'((64'd1 << 35) / 64'd30),  31'((64'd1 << 36) / 64'd56),
    31'((64'd1 << 37) / 64'd90),  31'((64'd1 << 38) / 64'd132),
    31'((64'd1 << 38) / 64'd182), 31'((64'd1 << 38) / 64'd240),
    31'((64'd1 << 39) / 64'd306), 31'((64'd1 << 39) / 64'd380),
    31'((64'd1 << 39) / 64'd462), 31'((64'd1 << 40) / 64'd552)};

  typedef enum logic [3:0] {
    DP_NOP, DP_LOAD, DP_DEC, DP_REDUCE, DP_INC, DP_FOLD, DP_RAD, DP_XLD,
    DP_SQR, DP_X2LD, DP_INIT, DP_TMUL, DP_TRCP, DP_TFIX, DP_FIN, DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t            op;
    logic [STEP_W-1:0] step;
    logic [K_W-1:0]    k;
    logic              second;
  } dp_cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_PREP, ST_RED, ST_INC, ST_FOLD, ST_RAD, ST_XLD, ST_SQR,
    ST_X2LD, ST_INIT, ST_TMUL, ST_TRCP, ST_TFIX, ST_SUMW, ST_FIN, ST_DONE
  } ctl_state_t;

endpackage

[hw/rtl/sct_datapath.sv]
`timescale 1ns / 1ps

module sct_datapath import sct_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic signed [ANGLE_W-1:0] angle_deg,
  output logic                     big,
  output logic signed [TRIG_W-1:0] sine,
  output logic signed [TRIG_W-1:0] cosine
);

  logic [23:0]        dval;
  logic [13:0]        u;
  logic               swap;
  logic [1:0]         quad;
  logic [63:0]        prod;
  logic [30:0]        x;
  logic [29:0]        x2;
  logic [30:0]        term;
  logic [29:0]        p;
  logic signed [31:0] sum;
  logic               acc_pend;
  logic               acc_neg;
  logic [16:0]        s1;
  logic [16:0]        c1;

  logic [23:0]        raw;
  logic [23:0]        red_sub;
  logic [14:0]        t_c;
  logic [1:0]         q_c;
  logic [13:0]        u_c;
  logic               swap_c;
  logic               is_cos;
  logic [K_W-1:0]     kidx;
  logic [9:0]         div_sel;
  logic [5:0]         shift_sel;
  logic [30:0]        rcp_sel;
  logic [32:0]        mul_a;
  logic [30:0]        mul_b;
  logic [29:0]        qe;
  logic [39:0]        qd;
  logic [29:0]        rem;
  logic               fix;
  logic signed [31:0] term_s;
  logic [30:0]        init_val;
  logic [30:0]        sc;
  logic [16:0]        rnd;
  logic signed [TRIG_W-1:0] s1_s;
  logic signed [TRIG_W-1:0] c1_s;

  assign raw = angle_deg;
  assign big = (dval > DEG_FULL);
  assign red_sub = DEG_FULL << cmd.step;

  // fold into the first quadrant, then mirror about 45 deg
  always_comb begin
    if (dval <= DEG_90) begin
      t_c = dval[14:0];
      q_c = 2'd0;
    end else if (dval <= DEG_180) begin
      t_c = 15'(DEG_180 - dval);
      q_c = 2'd1;
    end else if (dval <= DEG_270) begin
      t_c = 15'(DEG_270 - dval);
      q_c = 2'd2;
    end else begin
      t_c = 15'(DEG_FULL - dval);
      q_c = 2'd3;
    end
    swap_c = (t_c > T_45);
    u_c    = swap_c ? 14'(T_90 - t_c) : 14'(t_c);
  end

  assign is_cos    = swap ^ cmd.second;
  assign kidx      = (cmd.k == '0) ? '0 : cmd.k - K_W'(1);
  assign div_sel   = is_cos ? COS_DIV[kidx] : SIN_DIV[kidx];
  assign shift_sel = is_cos ? COS_SHIFT[kidx] : SIN_SHIFT[kidx];
  assign rcp_sel   = is_cos ? COS_RCP[kidx] : SIN_RCP[kidx];

  // shared multiplier operands
  always_comb begin
    case (cmd.op)
      DP_RAD: begin
        mul_a = RAD_Q46;
        mul_b = 31'(u);
      end
      DP_SQR: begin
        mul_a = 33'(x);
        mul_b = x;
      end
      DP_TMUL: begin
        mul_a = 33'(x2);
        mul_b = term;
      end
      DP_TRCP: begin
        mul_a = 33'(rcp_sel);
        mul_b = 31'(prod[59:30]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // quotient estimate is exact or one low; one compare fixes it
  assign qe   = 30'(prod >> shift_sel);
  assign qd   = qe * div_sel;
  assign rem  = p - qd[29:0];
  assign fix  = (rem >= 30'(div_sel));

  assign term_s   = $signed({1'b0, term});
  assign init_val = is_cos ? ONE_Q30 : x;

  // clamp to [0, 1] and round to 16 fraction bits
  always_comb begin
    if (sum[31]) begin
      sc = '0;
    end else if (sum > $signed({1'b0, ONE_Q30})) begin
      sc = ONE_Q30;
    end else begin
      sc = sum[30:0];
    end
    rnd = sc[30:14] + 17'(sc[13]);
  end

  assign s1_s = $signed({1'b0, s1});
  assign c1_s = $signed({1'b0, c1});

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_pend <= 1'b0;
    end else begin
      acc_pend <= (cmd.op == DP_TFIX);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op inside {DP_RAD, DP_SQR, DP_TMUL, DP_TRCP}) begin
      prod <= mul_a * mul_b;
    end
    // fold in the term finished last cycle
    if (acc_pend) begin
      sum <= acc_neg ? sum - term_s : sum + term_s;
    end
    case (cmd.op)
      DP_LOAD:   dval <= raw[23] ? (~raw + 24'd1) : raw;
      DP_DEC:    dval <= dval - 24'd1;
      DP_REDUCE: begin
        if (dval >= red_sub) begin
          dval <= dval - red_sub;
        end
      end
      DP_INC:    dval <= dval + 24'd1;
      DP_FOLD: begin
        u    <= u_c;
        swap <= swap_c;
        quad <= q_c;
      end
      DP_XLD:    x  <= prod[46:16] + 31'(prod[15]);
      DP_X2LD:   x2 <= prod[59:30] + 30'(prod[29]);
      DP_INIT: begin
        term <= init_val;
        sum  <= $signed({1'b0, init_val});
      end
      DP_TRCP:   p <= prod[59:30];
      DP_TFIX: begin
        term    <= 31'(qe) + 31'(fix);
        acc_neg <= cmd.k[0];
      end
      DP_FIN: begin
        if (cmd.second) begin
          c1 <= rnd;
        end else begin
          s1 <= rnd;
        end
      end
      DP_OUT: begin
        case (quad)
          2'd0: begin
            sine   <= s1_s;
            cosine <= c1_s;
          end
          2'd1: begin
            sine   <= s1_s;
            cosine <= -c1_s;
          end
          2'd2: begin
            sine   <= -c1_s;
            cosine <= -s1_s;
          end
          default: begin
            sine   <= -s1_s;
            cosine <= c1_s;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

[hw/rtl/sct_ctrl.sv]
`timescale 1ns / 1ps

module sct_ctrl import sct_pkg::*; #(
  parameter int unsigned MAX_TERMS = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  logic                    out_stall,
  input  logic                    cfg_valid,
  input  logic [TERM_COUNT_W-1:0] cfg_data,
  input  logic                    big,
  output dp_cmd_t                 cmd
);

  localparam int unsigned KC_W = $clog2(MAX_TERMS + 1);

  ctl_state_t              state, state_next;
  logic [STEP_W-1:0]       cnt, cnt_next;
  logic [KC_W-1:0]         k, k_next;
  logic                    second, second_next;
  logic                    out_valid_next;
  logic [TERM_COUNT_W-1:0] term_count;
  logic [KC_W-1:0]         n_terms;

  assign n_terms  = (term_count > TERM_COUNT_W'(MAX_TERMS)) ? KC_W'(MAX_TERMS)
                                                             : KC_W'(term_count);
  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      k          <= '0;
      second     <= 1'b0;
      out_valid  <= 1'b0;
      term_count <= TERM_COUNT_RESET;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      k         <= k_next;
      second    <= second_next;
      out_valid <= out_valid_next;
      if (cfg_valid) begin
        term_count <= cfg_data;
      end
    end
  end

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    k_next         = k;
    second_next    = second;
    out_valid_next = out_valid && out_stall;
    cmd.op         = DP_NOP;
    cmd.step       = cnt;
    cmd.k          = K_W'(k);
    cmd.second     = second;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op     = DP_LOAD;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (big) begin
          cmd.op     = DP_DEC;
          cnt_next   = RED_TOP;
          state_next = ST_RED;
        end else begin
          cmd.op     = DP_FOLD;
          state_next = ST_RAD;
        end
      end
      ST_RED: begin
        cmd.op = DP_REDUCE;
        if (cnt == '0) begin
          state_next = ST_INC;
        end else begin
          cnt_next = cnt - STEP_W'(1);
        end
      end
      ST_INC: begin
        cmd.op     = DP_INC;
        state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.op     = DP_FOLD;
        state_next = ST_RAD;
      end
      ST_RAD: begin
        cmd.op     = DP_RAD;
        state_next = ST_XLD;
      end
      ST_XLD: begin
        cmd.op     = DP_XLD;
        state_next = ST_SQR;
      end
      ST_SQR: begin
        cmd.op     = DP_SQR;
        state_next = ST_X2LD;
      end
      ST_X2LD: begin
        cmd.op      = DP_X2LD;
        second_next = 1'b0;
        state_next  = ST_INIT;
      end
      ST_INIT: begin
        cmd.op     = DP_INIT;
        k_next     = KC_W'(1);
        state_next = (n_terms == '0) ? ST_SUMW : ST_TMUL;
      end
      ST_TMUL: begin
        cmd.op     = DP_TMUL;
        state_next = ST_TRCP;
      end
      ST_TRCP: begin
        cmd.op     = DP_TRCP;
        state_next = ST_TFIX;
      end
      ST_TFIX: begin
        cmd.op = DP_TFIX;
        if (k == n_terms) begin
          state_next = ST_SUMW;
        end else begin
          k_next     = k + KC_W'(1);
          state_next = ST_TMUL;
        end
      end
      ST_SUMW: begin
        state_next = ST_FIN;
      end
      ST_FIN: begin
        cmd.op = DP_FIN;
        if (second) begin
          state_next = ST_DONE;
        end else begin
          second_next = 1'b1;
          state_next  = ST_INIT;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.op         = DP_OUT;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/sin_cos_taylor_degrees.sv]
`timescale 1ns / 1ps

// Sine and cosine of an angle in degrees by truncated Taylor series. The
// angle comes in as signed Q15.8 degrees; its magnitude is reduced to at
// most 360 (a nonzero multiple of 360 stays 360), folded into the first
// quadrant and mirrored about 45 degrees, converted to Q30 radians, and run
// through both series, each with n+1 terms where n = min(term_count,
// MAX_TERMS). Results are signed Q1.16 in [-65536, 65536]; each term is
// truncated after its divide, so the low bits follow that rounding and not
// the true sine. One item is in work at a time: in_stall is high from the
// accept until the result is loaded into the output register, and that
// load waits while the previous result is still held by out_stall. Above
// 360 degrees the work adds the 7-step turn reduction plus an entry and an
// exit step. The time per item is set by the single shared 33x31
// multiplier: every series term needs one product by x^2 and one
// reciprocal product, then a step to correct the quotient.
// A finished result sits in the output register while the next angle is
// accepted and worked on. term_count resets to 8 and is written through
// the cfg beat; write it only while the block is idle. cfg_ready is always
// high.
module sin_cos_taylor_degrees import sct_pkg::*; #(
  parameter int unsigned MAX_TERMS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] angle_deg,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [TRIG_W-1:0]  sine,
  output logic signed [TRIG_W-1:0]  cosine,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [TERM_COUNT_W-1:0]   cfg_data
);

  dp_cmd_t cmd;
  logic    big;

  // the register write never waits
  assign cfg_ready = 1'b1;

  // sequencer: reduction steps, series term loop, output hand-off
  sct_ctrl #(
    .MAX_TERMS(MAX_TERMS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .big       (big),
    .cmd       (cmd)
  );

  // angle registers, shared multiplier, series accumulator, output register
  sct_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .angle_deg (angle_deg),
    .big       (big),
    .sine      (sine),
    .cosine    (cosine)
  );

endmodule

[hw/rtl/sct_checker.sv]
`timescale 1ns / 1ps
`include "sin_cos_taylor_degrees_assert.svh"

module sct_checker import sct_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_stall,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [TRIG_W-1:0] sine,
  input logic signed [TRIG_W-1:0] cosine
);

  // one angle in work at a time: the input side closes after each beat
  `SCT_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)

  // hold a stalled result beat
  `SCT_ASSERT_NEXT(a_hold_stalled, clk, rst, out_valid && out_stall, out_valid && $stable(sine) && $stable(cosine))

  // the cosine-like series stays well away from zero, so both cannot vanish
  `SCT_ASSERT_NOW(a_result_nonzero, clk, rst, out_valid, sine != '0 || cosine != '0)

  // drop any pending result on reset
  `SCT_ASSERT_NEXT_ALWAYS(a_reset_clears, clk, rst, !out_valid)

endmodule

bind sin_cos_taylor_degrees sct_checker u_sct_checker (.*);

[verif/sin_cos_taylor_degrees_test.sv]
`timescale 1ns / 1ps

module sin_cos_taylor_degrees_test import sct_pkg::*;;

  localparam int unsigned MAX_TERMS = 8;

  // Angles in degrees with 8 fraction bits
  localparam int FULL_TURN    = 92160;
  localparam int THREE_FOURTH = 69120;
  localparam int HALF_TURN    = 46080;
  localparam int QUARTER_TURN = 23040;
  localparam int EIGHTH_TURN  = 11520;

  // Degrees to Q30 radians goes through pi/180 scaled to Q46
  localparam longint unsigned PI_Q60  = 64'h3243F6A8885A308D;
  localparam longint unsigned RAD_Q46 = (PI_Q60 / 64'd46080) >> 14;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ANGLES  = 188;

  typedef struct {
    logic signed [ANGLE_W-1:0] angle;
    logic signed [TRIG_W-1:0]  sine;
    logic signed [TRIG_W-1:0]  cosine;
  } trig_pair_t;

  // Holds the sine/cosine pairs still owed by the block and the term count
  // that the block was last given.
  class trig_book;
    trig_pair_t              awaited_pairs[$];
    logic [TERM_COUNT_W-1:0] term_count;
    int unsigned             mismatches;
    int unsigned             checked;

    function new();
      term_count = TERM_COUNT_RESET;
      mismatches = 0;
      checked    = 0;
    endfunction

    // Truncated series at a reduced angle of at most 45 degrees, Q16 out
    function int series_q16(longint unsigned deg_q8, bit cos_series);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned div;
      longint          sum;
      int unsigned     n;
      x    = (deg_q8 * RAD_Q46 + (64'd1 << 15)) >> 16;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = cos_series ? ONE_Q30 : x;
      sum  = longint'(term);
      n    = (term_count > MAX_TERMS) ? MAX_TERMS : term_count;
      for (int unsigned k = 1; k <= n; k++) begin
        div  = cos_series ? longint'((2 * k - 1) * (2 * k)) : longint'((2 * k) * (2 * k + 1));
        term = ((term * x2) >> 30) / div;
        if (k % 2 == 1) sum -= longint'(term);
        else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      return int'((sum + 64'd8192) >>> 14);
    endfunction

    function trig_pair_t predict_pair(logic signed [ANGLE_W-1:0] angle);
      trig_pair_t  pair;
      int unsigned mag;
      int unsigned t;
      int          s1;
      int          c1;
      int          sv;
      int          cv;
      // Magnitude; the most negative angle maps to 2^23 exactly
      mag = angle[ANGLE_W-1] ? (32'h0100_0000 - {8'd0, angle}) : {8'd0, angle};
      // Reduce by whole turns, keeping a nonzero multiple of 360 at 360
      if (mag > FULL_TURN) mag = (mag - 1) % FULL_TURN + 1;
      if (mag <= QUARTER_TURN) t = mag;
      else if (mag <= HALF_TURN) t = HALF_TURN - mag;
      else if (mag <= THREE_FOURTH) t = THREE_FOURTH - mag;
      else t = FULL_TURN - mag;
      // Mirror about 45 degrees by swapping the series
      if (t <= EIGHTH_TURN) begin
        s1 = series_q16(t, 1'b0);
        c1 = series_q16(t, 1'b1);
      end else begin
        s1 = series_q16(QUARTER_TURN - t, 1'b1);
        c1 = series_q16(QUARTER_TURN - t, 1'b0);
      end
      if (mag <= QUARTER_TURN) begin
        sv = s1;  cv = c1;
      end else if (mag <= HALF_TURN) begin
        sv = s1;  cv = -c1;
      end else if (mag <= THREE_FOURTH) begin
        sv = -c1; cv = -s1;
      end else begin
        sv = -s1; cv = c1;
      end
      pair.angle  = angle;
      pair.sine   = TRIG_W'(sv);
      pair.cosine = TRIG_W'(cv);
      return pair;
    endfunction

    function void note_angle(logic signed [ANGLE_W-1:0] angle);
      awaited_pairs.push_back(predict_pair(angle));
    endfunction

    function void check_pair(logic signed [TRIG_W-1:0] sine, logic signed [TRIG_W-1:0] cosine);
      trig_pair_t want;
      if (awaited_pairs.size() == 0) begin
        $error("unexpected result beat: sine %0d cosine %0d", sine, cosine);
        mismatches++;
        return;
      end
      want = awaited_pairs.pop_front();
      checked++;
      if (sine !== want.sine) begin
        $error("sine mismatch for angle %0d: expected %0d, actual %0d",
               want.angle, want.sine, sine);
        mismatches++;
      end
      if (cosine !== want.cosine) begin
        $error("cosine mismatch for angle %0d: expected %0d, actual %0d",
               want.angle, want.cosine, cosine);
        mismatches++;
      end
    endfunction
  endclass

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic signed [ANGLE_W-1:0] angle_deg = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [TRIG_W-1:0]  sine;
  logic signed [TRIG_W-1:0]  cosine;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [TERM_COUNT_W-1:0]   cfg_data  = '0;

  trig_book    book = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned angles_sent   = 0;

  sin_cos_taylor_degrees #(
    .MAX_TERMS(MAX_TERMS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .angle_deg(angle_deg),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sine     (sine),
    .cosine   (cosine),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  // Receiver: stall at random on the falling edge, take result beats on
  // the rising edge when valid and not stalled.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) book.check_pair(sine, cosine);
  end

  // Pick a random angle. Most land within two turns or next to an octant
  // boundary, some next to a large multiple of a full turn, the rest
  // anywhere in the 24-bit range.
  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    int unsigned pick;
    int          v;
    pick = $urandom_range(99);
    if (pick < 35) v = $urandom_range(2 * FULL_TURN);
    else if (pick < 60) v = $urandom_range(16) * EIGHTH_TURN + $urandom_range(8) - 4;
    else if (pick < 75) v = $urandom_range(91) * FULL_TURN + $urandom_range(6) - 3;
    else v = $urandom();
    if (pick < 75 && $urandom_range(1) == 1) v = -v;
    return v[ANGLE_W-1:0];
  endfunction

  // Offer one angle beat: idle at random first, then hold the beat until
  // the block takes it. Leave valid high so a back-to-back beat can follow.
  task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    angle_deg <= angle;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.note_angle(angle);
    angles_sent++;
  endtask

  // Drop valid and wait on the falling edge until every owed pair is in.
  task automatic hold_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.awaited_pairs.size() != 0) @(negedge clk);
  endtask

  // Write term_count; only called while the block is idle.
  task automatic write_term_count(input logic [TERM_COUNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.term_count = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Directed angles in Q15.8 degrees: octant and quadrant boundaries and
  // their neighbors, whole turns, negatives and both ends of the range.
  localparam int DIRECTED_COUNT = 24;
  localparam logic signed [ANGLE_W-1:0] DIRECTED_ANGLES [DIRECTED_COUNT] = '{
    24'sd0,       24'sd1,       24'sd11519,   24'sd11520,   24'sd11521,
    24'sd23040,   24'sd23041,   24'sd34560,   24'sd46080,   24'sd46081,
    24'sd57600,   24'sd69120,   24'sd69121,   24'sd80640,   24'sd92160,
    24'sd92161,   24'sd184320,  -24'sd23040,  -24'sd1,      -24'sd7680,
    24'sd5120,    24'sd256000,  24'sh7FFFFF,  24'sh800000};

  initial begin
    logic [TERM_COUNT_W-1:0] phase_terms [RANDOM_PHASES];

    // Cover both ends of the register, the saturation point and a few
    // values in between; the last one is drawn at random.
    phase_terms = '{4'd0, 4'd15, 4'd5, 4'd8, 4'd1, 4'd0};
    phase_terms[RANDOM_PHASES-1] = TERM_COUNT_W'($urandom_range(15));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed beats run at the reset term count, sender light, receiver heavy
    send_idle_pct = 27;
    recv_idle_pct = 85;
    for (int i = 0; i < DIRECTED_COUNT; i++) send_angle(DIRECTED_ANGLES[i]);
    hold_until_drained();

    // Random phases: first two keep the heavy receiver, the next two swap
    // the idling around, the last two run with no idling at all.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 27;
        recv_idle_pct = 85;
      end else if (p < 4) begin
        send_idle_pct = 85;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_term_count(phase_terms[p]);
      for (int i = 0; i < PHASE_ANGLES; i++) begin
        // Halfway through, let the pipeline run completely dry once
        if (i == PHASE_ANGLES / 2) hold_until_drained();
        send_angle(pick_angle());
      end
      hold_until_drained();
    end

    // Give any stray result beat time to show up as unexpected
    repeat (100) @(posedge clk);

    $display("%0d angles sent over %0d term_count settings, %0d sine/cosine pairs checked",
             angles_sent, RANDOM_PHASES + 1, book.checked);
    if (book.mismatches == 0) begin
      $display("sin_cos_taylor_degrees_test passed");
    end else begin
      $display("sin_cos_taylor_degrees_test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (about 2 ms)
  initial begin
    #20_000_000;
    $display("sin_cos_taylor_degrees_test failed");
    $finish;
  end

endmodule
